>>> design/bracket_expression_compiler_core_macros.svh
// Assertion helpers used by the compiler core.
`ifndef BRACKET_EXPRESSION_COMPILER_CORE_MACROS_SVH
`define BRACKET_EXPRESSION_COMPILER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BCE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg
// Types, codes and character-class tables of the bracket expression compiler.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int unsigned SetWordsDef     = 8;
  localparam int unsigned WordWidthDef    = 32;
  localparam int unsigned PositionBitsDef = 16;
  localparam int unsigned SetBits         = 256;
  localparam int unsigned NumClasses      = 13;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadEq    = 3'd1;
  localparam logic [2:0] StClassEnd = 3'd2;
  localparam logic [2:0] StBadClass = 3'd3;
  localparam logic [2:0] StNoClose  = 3'd4;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       first_byte;
  } bce_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  word_index;
    logic [31:0] set_word;
    logic [15:0] close_position;
    logic        last;
  } bce_out_t;

  // What one input byte asks of the set memory
  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_MASK = 2'd1,
    K_EMIT = 2'd2,
    K_ERR  = 2'd3
  } bce_kind_e;

  typedef struct packed {
    bce_kind_e  kind;
    logic [2:0] status;
    logic       comp;
  } bce_step_t;

  // Bits lo..hi set
  function automatic logic [SetBits-1:0] range_mask(input logic [7:0] lo,
                                                    input logic [7:0] hi);
    logic [SetBits-1:0] m;
    m = '0;
    for (int c = 0; c < SetBits; c++) begin
      m[c] = (8'(c) >= lo) && (8'(c) <= hi);
    end
    return m;
  endfunction

  function automatic logic [3:0] class_len(input logic [3:0] idx);
    return (idx == 4'd11) ? 4'd10 : 4'd9;
  endfunction

  // Character of a class name at a given offset, zero past the end
  function automatic logic [7:0] class_name_char(input logic [3:0] idx,
                                                 input logic [4:0] off);
    logic [79:0] s;
    int          l;
    int          p;
    unique case (idx)
      4'd0:    s = "[:alnum:]";
      4'd1:    s = "[:alpha:]";
      4'd2:    s = "[:blank:]";
      4'd3:    s = "[:cntrl:]";
      4'd4:    s = "[:digit:]";
      4'd5:    s = "[:graph:]";
      4'd6:    s = "[:lower:]";
      4'd7:    s = "[:print:]";
      4'd8:    s = "[:punct:]";
      4'd9:    s = "[:space:]";
      4'd10:   s = "[:upper:]";
      4'd11:   s = "[:xdigit:]";
      default: s = "[:undef:]";
    endcase
    l = int'(class_len(idx));
    p = l - 1 - int'(off);
    if (p < 0) return 8'd0;
    return s[p*8 +: 8];
  endfunction

  function automatic logic [SetBits-1:0] class_mask(input logic [3:0] idx);
    logic [SetBits-1:0] m;
    unique case (idx)
      4'd0:  m = range_mask("0", "9") | range_mask("A", "Z") | range_mask("a", "z");
      4'd1:  m = range_mask("A", "Z") | range_mask("a", "z");
      4'd2:  m = range_mask(8'd32, 8'd32) | range_mask(8'd9, 8'd9);
      4'd3:  m = range_mask(8'd0, 8'd31);
      4'd4:  m = range_mask("0", "9");
      4'd5:  m = range_mask(8'd33, 8'd126);
      4'd6:  m = range_mask("a", "z");
      4'd7:  m = range_mask(8'd32, 8'd126);
      4'd8:  m = range_mask(8'd33, 8'd47) | range_mask(8'd58, 8'd64) |
                 range_mask(8'd91, 8'd96) | range_mask(8'd123, 8'd126);
      4'd9:  m = range_mask(8'd32, 8'd32) | range_mask(8'd9, 8'd13);
      4'd10: m = range_mask("A", "Z");
      4'd11: m = range_mask("0", "9") | range_mask("A", "F") | range_mask("a", "f");
      default: m = range_mask(8'd128, 8'd255);
    endcase
    return m;
  endfunction

endpackage

>>> design/bce_ram.sv
// ----------------------------------------------------------------------------
// bce_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bce_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/bce_parse.sv
// ----------------------------------------------------------------------------
// bce_parse
// Byte parser: holds the scalar parse state and turns each byte into a set
// mask to merge, an emit request or an error.
// ----------------------------------------------------------------------------
module bce_parse import bce_pkg::*; #(
  parameter int unsigned PositionBits = PositionBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  bce_in_t            item_i,
  output bce_step_t          step_o,
  output logic [SetBits-1:0] mask_o,
  output logic [15:0]        close_pos_o
);

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_NORMAL   = 7'b0000010,
    PH_OPEN     = 7'b0000100,
    PH_EQ_CHAR  = 7'b0001000,
    PH_EQ_DELIM = 7'b0010000,
    PH_EQ_CLOSE = 7'b0100000,
    PH_CLASS    = 7'b1000000
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic                    comp_q, comp_d;
  logic                    dash_q, dash_d;
  logic                    sv_q, sv_d;
  logic [7:0]              sc_q, sc_d;
  logic [NumClasses-1:0]   cand_q, cand_d;
  logic [3:0]              moff_q, moff_d;
  logic                    delim_q, delim_d;
  logic [7:0]              cchar_q, cchar_d;
  logic [PositionBits-1:0] pos_q, pos_d;
  logic                    fin_q, fin_d;

  // Next parse state and memory request for the offered byte
  always_comb begin
    logic [7:0]              b;
    logic [SetBits-1:0]      m;
    logic                    act;
    logic                    do_norm;
    logic                    hit_f;
    logic [3:0]              hit;
    logic [4:0]              off;
    logic [NumClasses-1:0]   alive;
    logic [PositionBits+16:0] pext;
    bce_step_t               st;

    b       = item_i.char_byte;
    m       = '0;
    act     = 1'b1;
    do_norm = 1'b0;
    hit_f   = 1'b0;
    hit     = '0;
    alive   = '0;
    off     = 5'd2 + {1'b0, moff_q};
    st      = '{kind: K_NONE, status: StOk, comp: comp_q};

    phase_d = phase_q;
    comp_d  = comp_q;
    dash_d  = dash_q;
    sv_d    = sv_q;
    sc_d    = sc_q;
    cand_d  = cand_q;
    moff_d  = moff_q;
    delim_d = delim_q;
    cchar_d = cchar_q;
    pos_d   = pos_q;
    fin_d   = fin_q;

    if (item_i.first_byte) begin
      comp_d  = 1'b0;
      dash_d  = 1'b0;
      sv_d    = 1'b0;
      sc_d    = '0;
      cand_d  = '1;
      moff_d  = '0;
      delim_d = 1'b0;
      cchar_d = '0;
      pos_d   = '0;
      fin_d   = 1'b0;
      phase_d = PH_NORMAL;
    end else if (fin_q) begin
      act = 1'b0;
    end

    if (act) begin
      unique case (phase_d)
        PH_OPEN: begin
          if (b == "=" || b == ".") begin
            delim_d = (b == ".");
            phase_d = PH_EQ_CHAR;
          end else if (b == ":") begin
            if (dash_d) begin
              st.kind = K_ERR; st.status = StClassEnd;
              fin_d = 1'b1; phase_d = PH_IDLE;
            end else begin
              if (sv_d) m = m | range_mask(sc_d, sc_d);
              sv_d    = 1'b0;
              cand_d  = '1;
              moff_d  = '0;
              phase_d = PH_CLASS;
            end
          end else begin
            // bare bracket becomes a plain element
            if (dash_d && sv_d) begin
              m = m | range_mask(sc_d, "[");
              sv_d = 1'b0; dash_d = 1'b0;
            end else begin
              if (sv_d) m = m | range_mask(sc_d, sc_d);
              if (!dash_d) begin sc_d = "["; sv_d = 1'b1; end
            end
            phase_d = PH_NORMAL;
            do_norm = 1'b1;
          end
        end
        PH_EQ_CHAR: begin
          if (b == 8'd0) begin
            st.kind = K_ERR; st.status = StBadEq; fin_d = 1'b1; phase_d = PH_IDLE;
          end else begin
            cchar_d = b;
            phase_d = PH_EQ_DELIM;
          end
        end
        PH_EQ_DELIM: begin
          if (b != (delim_d ? 8'(".") : 8'("="))) begin
            st.kind = K_ERR; st.status = StBadEq; fin_d = 1'b1; phase_d = PH_IDLE;
          end else begin
            phase_d = PH_EQ_CLOSE;
          end
        end
        PH_EQ_CLOSE: begin
          if (b != "]") begin
            st.kind = K_ERR; st.status = StBadEq; fin_d = 1'b1; phase_d = PH_IDLE;
          end else begin
            if (dash_d && sv_d) begin
              m = m | range_mask(sc_d, cchar_d);
              sv_d = 1'b0; dash_d = 1'b0;
            end else begin
              if (sv_d) m = m | range_mask(sc_d, sc_d);
              if (!dash_d) begin sc_d = cchar_d; sv_d = 1'b1; end
            end
            phase_d = PH_NORMAL;
          end
        end
        PH_CLASS: begin
          // narrow the candidate names by one character
          for (int i = NumClasses - 1; i >= 0; i--) begin
            if (cand_q[i] && ({1'b0, off} < {1'b0, class_len(4'(i))}) &&
                class_name_char(4'(i), off) == b) begin
              alive[i] = 1'b1;
              if ({1'b0, off} + 5'd1 == {1'b0, class_len(4'(i))}) begin
                hit_f = 1'b1; hit = 4'(i);
              end
            end
          end
          cand_d = alive;
          if (alive == '0) begin
            st.kind = K_ERR; st.status = StBadClass; fin_d = 1'b1; phase_d = PH_IDLE;
          end else if (hit_f) begin
            m = m | class_mask(hit);
            phase_d = PH_NORMAL;
          end else begin
            moff_d = moff_q + 4'd1;
          end
        end
        default: do_norm = 1'b1;
      endcase

      if (do_norm) begin
        priority if (b == 8'd0) begin
          st.kind = K_ERR; st.status = StNoClose; fin_d = 1'b1; phase_d = PH_IDLE;
        end else if (b == "^" && pos_d == '0) begin
          comp_d = 1'b1;
        end else if (b == "]" && pos_d > (comp_d ? PositionBits'(1) : '0)) begin
          if (dash_d) m = m | range_mask("-", "-");
          if (sv_d)   m = m | range_mask(sc_d, sc_d);
          st.kind = K_EMIT; fin_d = 1'b1; phase_d = PH_IDLE;
        end else if (b == "[") begin
          phase_d = PH_OPEN;
        end else begin
          if (dash_d && sv_d) begin
            m = m | range_mask(sc_d, b);
            sv_d = 1'b0; dash_d = 1'b0;
          end else begin
            if (sv_d && b == "-") dash_d = 1'b1;
            else if (sv_d) m = m | range_mask(sc_d, sc_d);
            if (!dash_d) begin sc_d = b; sv_d = 1'b1; end
          end
        end
      end

      if (st.kind == K_NONE && m != '0) st.kind = K_MASK;
      if (!fin_d && pos_d != '1) pos_d = pos_d + PositionBits'(1);
    end

    st.comp = comp_d;
    step_o  = st;
    mask_o  = m;
    // offset of the closing bracket is the offset before the step
    pext        = (PositionBits + 17)'(pos_q);
    close_pos_o = (pext > (PositionBits + 17)'(16'hFFFF)) ? 16'hFFFF : pext[15:0];
  end

  // Commit the parse state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      comp_q  <= 1'b0;
      dash_q  <= 1'b0;
      sv_q    <= 1'b0;
      sc_q    <= '0;
      cand_q  <= '1;
      moff_q  <= '0;
      delim_q <= 1'b0;
      cchar_q <= '0;
      pos_q   <= '0;
      fin_q   <= 1'b1;
    end else if (accept_i) begin
      phase_q <= phase_d;
      comp_q  <= comp_d;
      dash_q  <= dash_d;
      sv_q    <= sv_d;
      sc_q    <= sc_d;
      cand_q  <= cand_d;
      moff_q  <= moff_d;
      delim_q <= delim_d;
      cchar_q <= cchar_d;
      pos_q   <= pos_d;
      fin_q   <= fin_d;
    end
  end

endmodule

>>> design/bracket_expression_compiler_core.sv
// ----------------------------------------------------------------------------
// bracket_expression_compiler_core
// Builds a 256-bit membership set from the body of a bracket expression.
// ----------------------------------------------------------------------------
// Feed the bytes after the opening '[' one per transfer, first_byte high on
// the first. A byte that leaves the set unchanged needs no RAM sweep; a byte
// that adds members starts a sweep in which the eight set words in the word
// RAM are read, merged and written back one per cycle. The closing bracket
// streams the eight set words out, each by a RAM read and then the output
// register, stalled by out_ready_i. An error gives a single result word.
// Input is held off while any result still sits in the output register.
`include "bracket_expression_compiler_core_macros.svh"

module bracket_expression_compiler_core import bce_pkg::*; #(
  parameter int unsigned SET_WORDS     = SetWordsDef,
  parameter int unsigned WORD_WIDTH    = WordWidthDef,
  parameter int unsigned POSITION_BITS = PositionBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bce_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bce_out_t out_item_o
);

  localparam int unsigned AddrBits = $clog2(SET_WORDS);
  localparam int unsigned CntBits  = AddrBits + 1;
  localparam int unsigned MaskBits = SET_WORDS * WORD_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_ERD  = 4'b0100,
    S_ELD  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [MaskBits-1:0] mask_q, mask_d;
  logic                comp_q, comp_d;
  logic [15:0]         cpos_q, cpos_d;
  logic [SET_WORDS-1:0] wvld_q, wvld_d;
  logic                rv_q;
  logic                out_valid_q, out_valid_d;
  bce_out_t            out_q, out_d;

  logic                in_xfer;
  bce_step_t           step;
  logic [SetBits-1:0]  pmask;
  logic [15:0]         pcpos;

  logic                re, we;
  logic [AddrBits-1:0] raddr, waddr;
  logic [WORD_WIDTH-1:0] wdata, rdata, rword;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_xfer    = in_valid_i && in_ready_o;

  bce_parse #(
    .PositionBits(POSITION_BITS)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_xfer),
    .item_i     (in_item_i),
    .step_o     (step),
    .mask_o     (pmask),
    .close_pos_o(pcpos)
  );

  bce_ram #(
    .Width(WORD_WIDTH),
    .Depth(SET_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Words not yet written this expression read as empty
  assign rword = rv_q ? rdata : '0;

  // Sequence the read-merge-write sweep and the result stream
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mask_d      = mask_q;
    comp_d      = comp_q;
    cpos_d      = cpos_q;
    wvld_d      = wvld_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    re          = 1'b0;
    we          = 1'b0;
    raddr       = cnt_q[AddrBits-1:0];
    waddr       = AddrBits'(cnt_q - CntBits'(1));
    wdata       = rword | mask_q[waddr*WORD_WIDTH +: WORD_WIDTH];

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_item_i.first_byte) wvld_d = '0;
          cnt_d  = '0;
          mask_d = MaskBits'(pmask);
          comp_d = step.comp;
          cpos_d = pcpos;
          unique case (step.kind)
            K_MASK: state_d = S_UPD;
            K_EMIT: state_d = S_ERD;
            K_ERR: begin
              out_valid_d = 1'b1;
              out_d = '{status: step.status, word_index: '0, set_word: '0,
                        close_position: '0, last: 1'b1};
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_UPD: begin
        re = (cnt_q < CntBits'(SET_WORDS));
        we = (cnt_q != '0);
        if (we) wvld_d[waddr] = 1'b1;
        if (cnt_q == CntBits'(SET_WORDS)) state_d = S_IDLE;
        else cnt_d = cnt_q + CntBits'(1);
      end
      S_ERD: begin
        re      = 1'b1;
        state_d = S_ELD;
      end
      S_ELD: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d = '{status: StOk, word_index: 3'(cnt_q[AddrBits-1:0]),
                    set_word: (rword | mask_q[raddr*WORD_WIDTH +: WORD_WIDTH]) ^
                              {WORD_WIDTH{comp_q}},
                    close_position: cpos_q,
                    last: (cnt_q == CntBits'(SET_WORDS - 1))};
          if (cnt_q == CntBits'(SET_WORDS - 1)) state_d = S_IDLE;
          else begin
            cnt_d   = cnt_q + CntBits'(1);
            state_d = S_ERD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      wvld_q      <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wvld_q      <= wvld_d;
      if (re) rv_q <= wvld_q[raddr];
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    comp_q <= comp_d;
    cpos_q <= cpos_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `BCE_ASSERT_IMPL(a_ready_no_pending, clk_i, rst_ni, in_ready_o, !out_valid_o, "input ready with a result pending")
  `BCE_ASSERT_IMPL(a_wr_in_sweep, clk_i, rst_ni, we, state_q == S_UPD, "RAM write outside merge sweep")
  `BCE_ASSERT_IMPL(a_no_rw_clash, clk_i, rst_ni, we && re, waddr != raddr, "read and write hit the same word")
  `BCE_ASSERT_IMPL(a_stream_open, clk_i, rst_ni, out_valid_o && !out_item_o.last, state_q == S_ERD || state_q == S_ELD, "set stream stopped before last word")
  `BCE_ASSERT_NEXT(a_err_single, clk_i, rst_ni, in_xfer && step.kind == K_ERR, out_valid_o && out_item_o.last && state_q == S_IDLE, "error result not single")

endmodule

>>> tb/bce_set_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_set_checker
// Watches both channels of the bracket expression compiler, rebuilds the
// membership set for every accepted byte and compares each result transfer
// field by field with the oldest predicted set word.
// ----------------------------------------------------------------------------
module bce_set_checker import bce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  bce_in_t     in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  bce_out_t    out_item_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned sets_seen_o,
  output int unsigned errors_seen_o
);

  typedef enum logic [3:0] {
    PhIdle, PhNormal, PhOpen, PhEqChar, PhEqDelim, PhEqClose, PhClass
  } phase_e;

  localparam int          ClassCount = 13;
  localparam logic [7:0]  ChClose    = "]";
  localparam logic [7:0]  ChOpen     = "[";
  localparam logic [7:0]  ChDash     = "-";
  localparam logic [7:0]  ChCaret    = "^";
  localparam logic [7:0]  ChColon    = ":";
  localparam logic [7:0]  ChEqual    = "=";
  localparam logic [7:0]  ChDot      = ".";
  localparam logic [15:0] PosMax     = 16'hFFFF;

  string class_text [ClassCount] = '{
    "[:alnum:]", "[:alpha:]", "[:blank:]", "[:cntrl:]", "[:digit:]",
    "[:graph:]", "[:lower:]", "[:print:]", "[:punct:]", "[:space:]",
    "[:upper:]", "[:xdigit:]", "[:undef:]"
  };

  // Predicted parser state
  logic [255:0]  members;
  logic          complement;
  logic          dash_pending;
  logic          anchor_valid;
  logic [7:0]    anchor_char;
  phase_e        phase;
  logic [12:0]   candidates;
  logic [3:0]    name_offset;
  logic          dot_form;
  logic [7:0]    single_char;
  logic [15:0]   position;
  logic          done;

  bce_out_t expected_words [$];

  function automatic logic [255:0] span(input int lo, input int hi);
    logic [255:0] m;
    m = '0;
    for (int c = 0; c < 256; c++) m[c] = (c >= lo) && (c <= hi);
    return m;
  endfunction

  function automatic logic [255:0] class_members(input int idx);
    case (idx)
      0:  return span("0", "9") | span("A", "Z") | span("a", "z");
      1:  return span("A", "Z") | span("a", "z");
      2:  return span(32, 32) | span(9, 9);
      3:  return span(0, 31);
      4:  return span("0", "9");
      5:  return span(33, 126);
      6:  return span("a", "z");
      7:  return span(32, 126);
      8:  return span(33, 47) | span(58, 64) | span(91, 96) | span(123, 126);
      9:  return span(32, 32) | span(9, 13);
      10: return span("A", "Z");
      11: return span("0", "9") | span("A", "F") | span("a", "f");
      default: return span(128, 255);
    endcase
  endfunction

  task automatic clear_state();
    members      = '0;
    complement   = 1'b0;
    dash_pending = 1'b0;
    anchor_valid = 1'b0;
    anchor_char  = '0;
    phase        = PhIdle;
    candidates   = '1;
    name_offset  = '0;
    dot_form     = 1'b0;
    single_char  = '0;
    position     = '0;
  endtask

  task automatic predict_error(input logic [2:0] code);
    bce_out_t r;
    r = '{status: code, word_index: 3'd0, set_word: 32'd0, close_position: 16'd0,
          last: 1'b1};
    expected_words.push_back(r);
    done  = 1'b1;
    phase = PhIdle;
  endtask

  task automatic predict_set();
    bce_out_t     r;
    logic [255:0] final_set;
    if (dash_pending) members[ChDash] = 1'b1;
    if (anchor_valid) members[anchor_char] = 1'b1;
    final_set = complement ? ~members : members;
    for (int k = 0; k < 8; k++) begin
      r = '{status: StOk, word_index: 3'(k), set_word: final_set[32*k +: 32],
            close_position: position, last: (k == 7)};
      expected_words.push_back(r);
    end
    done  = 1'b1;
    phase = PhIdle;
  endtask

  // Close a pending range or push a new range start
  task automatic take_element(input logic [7:0] c, input logic dash_ok);
    if (dash_pending && anchor_valid) begin
      members      = members | span(anchor_char, c);
      anchor_valid = 1'b0;
      dash_pending = 1'b0;
    end else begin
      if (dash_ok && anchor_valid && c == ChDash) dash_pending = 1'b1;
      else if (anchor_valid) members[anchor_char] = 1'b1;
      if (!dash_pending) begin
        anchor_char  = c;
        anchor_valid = 1'b1;
      end
    end
  endtask

  task automatic plain_byte(input logic [7:0] b);
    if (b == 8'd0) predict_error(StNoClose);
    else if (b == ChCaret && position == 0) complement = 1'b1;
    else if (b == ChClose && position > (complement ? 16'd1 : 16'd0)) predict_set();
    else if (b == ChOpen) phase = PhOpen;
    else take_element(b, 1'b1);
  endtask

  task automatic class_name_byte(input logic [7:0] b);
    int          off;
    int          hit;
    logic [12:0] alive;
    off   = 2 + int'(name_offset);
    hit   = ClassCount;
    alive = '0;
    for (int i = 0; i < ClassCount; i++) begin
      if (candidates[i] && off < class_text[i].len() && class_text[i][off] == b) begin
        alive[i] = 1'b1;
        if (off + 1 == class_text[i].len() && hit == ClassCount) hit = i;
      end
    end
    candidates = alive;
    if (alive == '0) predict_error(StBadClass);
    else if (hit < ClassCount) begin
      members = members | class_members(hit);
      phase   = PhNormal;
    end else name_offset = name_offset + 4'd1;
  endtask

  task automatic parse_byte(input bce_in_t it);
    logic [7:0] b;
    b = it.char_byte;
    if (it.first_byte) begin
      clear_state();
      done  = 1'b0;
      phase = PhNormal;
    end else if (done) return;
    case (phase)
      PhOpen: begin
        if (b == ChEqual || b == ChDot) begin
          dot_form = (b == ChDot);
          phase    = PhEqChar;
        end else if (b == ChColon) begin
          if (dash_pending) predict_error(StClassEnd);
          else begin
            if (anchor_valid) members[anchor_char] = 1'b1;
            anchor_valid = 1'b0;
            candidates   = '1;
            name_offset  = '0;
            phase        = PhClass;
          end
        end else begin
          take_element(ChOpen, 1'b1);
          phase = PhNormal;
          plain_byte(b);
        end
      end
      PhEqChar: begin
        if (b == 8'd0) predict_error(StBadEq);
        else begin
          single_char = b;
          phase       = PhEqDelim;
        end
      end
      PhEqDelim: begin
        if (b != (dot_form ? ChDot : ChEqual)) predict_error(StBadEq);
        else phase = PhEqClose;
      end
      PhEqClose: begin
        if (b != ChClose) predict_error(StBadEq);
        else begin
          take_element(single_char, 1'b0);
          phase = PhNormal;
        end
      end
      PhClass: class_name_byte(b);
      default: plain_byte(b);
    endcase
    if (!done && position < PosMax) position = position + 16'd1;
  endtask

  // Compare result transfers, then advance the prediction on input transfers
  always @(posedge clk_i or negedge rst_ni) begin
    bce_out_t want;
    if (!rst_ni) begin
      clear_state();
      done = 1'b1;
      expected_words.delete();
      fail_count_o  <= 0;
      pending_o     <= 0;
      sets_seen_o   <= 0;
      errors_seen_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result transfer %p", out_item_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_words.pop_front();
          if (want != out_item_i) fail_count_o <= fail_count_o + 1;
          if (want.status != out_item_i.status)
            $error("status: expected %0d, got %0d", want.status, out_item_i.status);
          if (want.word_index != out_item_i.word_index)
            $error("word_index: expected %0d, got %0d", want.word_index,
                   out_item_i.word_index);
          if (want.set_word != out_item_i.set_word)
            $error("set_word: expected %h, got %h", want.set_word, out_item_i.set_word);
          if (want.close_position != out_item_i.close_position)
            $error("close_position: expected %0d, got %0d", want.close_position,
                   out_item_i.close_position);
          if (want.last != out_item_i.last)
            $error("last: expected %0d, got %0d", want.last, out_item_i.last);
          if (want.last && want.status == StOk) sets_seen_o <= sets_seen_o + 1;
          if (want.status != StOk) errors_seen_o <= errors_seen_o + 1;
        end
      end
      if (in_valid_i && in_ready_i) parse_byte(in_item_i);
      pending_o <= expected_words.size();
    end
  end

endmodule

>>> tb/tb_bracket_expression_compiler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bracket_expression_compiler_core
// Feeds directed and random bracket expressions into the compiler core with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_bracket_expression_compiler_core;
  import bce_pkg::*;

  localparam int RandomBytes = 290;
  localparam int GappedBytes = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  bce_in_t     in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  bce_out_t    out_item_o;
  logic        gaps_on = 1'b1;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned sets_seen;
  int unsigned errors_seen;

  bce_in_t byte_stream [$];
  logic    opening;
  int      random_count;

  string class_text [13] = '{
    "[:alnum:]", "[:alpha:]", "[:blank:]", "[:cntrl:]", "[:digit:]",
    "[:graph:]", "[:lower:]", "[:print:]", "[:punct:]", "[:space:]",
    "[:upper:]", "[:xdigit:]", "[:undef:]"
  };

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  bracket_expression_compiler_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  bce_set_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_item_i(out_item_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .sets_seen_o(sets_seen), .errors_seen_o(errors_seen)
  );

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_ready_i <= gaps_on ? ($urandom_range(99) >= 31) : 1'b1;
  end

  // Queue one byte; the first after opening is set carries first_byte
  task automatic put(input logic [7:0] b);
    byte_stream.push_back('{char_byte: b, first_byte: opening});
    opening = 1'b0;
    random_count++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic logic [7:0] any_literal();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (c == "]" || c == "[") c = "q";
    return c;
  endfunction

  // One random expression, mostly well formed
  task automatic build_expression();
    string name;
    int    pick;
    opening = 1'b1;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 4))
        byte_stream.push_back('{char_byte: 8'($urandom), first_byte: 1'($urandom)});
      random_count++;
      return;
    end
    if ($urandom_range(99) < 20) put("^");
    if ($urandom_range(99) < 15) put("]");
    repeat ($urandom_range(1, 5)) begin
      pick = $urandom_range(9);
      case (pick)
        0, 1: put(any_literal());
        2, 3: begin
          put(any_literal());
          put("-");
          if ($urandom_range(9) == 0) put_text(class_text[$urandom_range(12)]);
          else put(any_literal());
        end
        4, 5: begin
          name = class_text[$urandom_range(12)];
          if ($urandom_range(9) == 0) name[$urandom_range(2, name.len() - 1)] = any_literal();
          put_text(name);
        end
        6: begin
          put("[");
          put($urandom_range(1) ? "=" : ".");
          put(any_literal());
          put($urandom_range(7) == 0 ? any_literal() : byte_stream[$][8:1] == "=" ?
              8'("=") : byte_stream[$-1].char_byte);
          put("]");
        end
        7: begin
          put("[");
          put(any_literal());
        end
        8: put("-");
        default: put(8'($urandom_range(1, 255)));
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 85) put("]");
    else if (pick < 92) put(8'd0);
    if ($urandom_range(99) < 15)
      byte_stream.push_back('{char_byte: any_literal(), first_byte: 1'b0});
  endtask

  task automatic send(input bce_in_t it);
    while (gaps_on && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    while (byte_stream.size() != 0) send(byte_stream.pop_front());
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    opening      = 1'b0;
    random_count = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: literal close first, complement, reversed range, trailing dash
    opening = 1'b1; put_text("^]z-a-]");
    opening = 1'b1; put_text("[x]");
    opening = 1'b1; put_text("[=q]");
    byte_stream.push_back('{char_byte: "k", first_byte: 1'b0});
    opening = 1'b1; put_text("a-[:");
    opening = 1'b1; put_text("[:bo");
    opening = 1'b1; put_text("ab");
    opening = 1'b1; put(8'd0);
    opening = 1'b1; put(8'hFF); put("]");
    drain();

    // Random expressions with gaps and stalls
    random_count = 0;
    while (random_count < GappedBytes) build_expression();
    drain();

    // Random expressions back to back, no gaps and no stalls
    gaps_on = 1'b0;
    while (random_count < RandomBytes) build_expression();
    drain();

    repeat (60) @(posedge clk_i);
    $display("Covered %0d completed sets and %0d error results,", sets_seen, errors_seen);
    $display("over directed forms and random expressions, with and without stalls.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
